@@ rtl/ckre_pkg.sv @@
// Shared types and constants for the color key run extractor.
package ckre_pkg;

    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned CFG_W    = 13;
    localparam int unsigned CFG_IDXW = 3;
    localparam int unsigned SIZE_W   = 13;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

    // Configuration register indexes.
    localparam logic [CFG_IDXW-1:0] REG_KEY_RED      = 3'd0;
    localparam logic [CFG_IDXW-1:0] REG_KEY_GREEN    = 3'd1;
    localparam logic [CFG_IDXW-1:0] REG_KEY_BLUE     = 3'd2;
    localparam logic [CFG_IDXW-1:0] REG_TOL_RED      = 3'd3;
    localparam logic [CFG_IDXW-1:0] REG_TOL_GREEN    = 3'd4;
    localparam logic [CFG_IDXW-1:0] REG_TOL_BLUE     = 3'd5;
    localparam logic [CFG_IDXW-1:0] REG_IMAGE_WIDTH  = 3'd6;
    localparam logic [CFG_IDXW-1:0] REG_IMAGE_HEIGHT = 3'd7;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] key_red;
        logic [CHAN_W-1:0] key_green;
        logic [CHAN_W-1:0] key_blue;
        logic [CHAN_W-1:0] tol_red;
        logic [CHAN_W-1:0] tol_green;
        logic [CHAN_W-1:0] tol_blue;
    } key_cfg_t;

endpackage

@@ rtl/color_key_run_extractor.sv @@
// Top level of the color key run extractor: raster pixels in, opaque runs and frame box out.
//
//  channel  direction  handshake              payload
//  -------  ---------  ---------------------  ---------------------------------------------
//  in       input      in_valid / in_stall    pix_red, pix_green, pix_blue
//  out      output     out_valid / out_stall  run_valid, run_begin, run_end, run_row,
//                                             box_left, box_top, box_right, box_bottom,
//                                             frame_end
//  cfg      input      cfg_write              cfg_index, cfg_data
//
// One pixel word is taken per cycle while in_stall is low; an accepted pixel waits in the input
// register, and the result register loads its word once the result side is free.
// Throughput is set by the single compare-and-count stage between the two registers.
// Reset clears the counters, run state and bounding box and restores the default settings.
// A stall on the result side holds the result register and the input register in place,
// and in_stall rises only while both are full.
module color_key_run_extractor
#(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned MAX_HEIGHT = 4096
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_write,
    input  logic [ckre_pkg::CFG_IDXW-1:0]   cfg_index,
    input  logic [ckre_pkg::CFG_W-1:0]      cfg_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ckre_pkg::CHAN_W-1:0]     pix_red,
    input  logic [ckre_pkg::CHAN_W-1:0]     pix_green,
    input  logic [ckre_pkg::CHAN_W-1:0]     pix_blue,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            run_valid,
    output logic [11:0]                     run_begin,
    output logic [12:0]                     run_end,
    output logic [11:0]                     run_row,
    output logic [12:0]                     box_left,
    output logic [12:0]                     box_top,
    output logic [12:0]                     box_right,
    output logic [12:0]                     box_bottom,
    output logic                            frame_end
);

    // Column and row counters are sized from the frame limits; the size registers
    // are widened to hold the limit itself.
    localparam int unsigned CW  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int unsigned RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int unsigned SW  = CW + 1;
    localparam int unsigned HW  = RW + 1;
    localparam int unsigned ZWW = (SW > ckre_pkg::SIZE_W) ? SW : ckre_pkg::SIZE_W;
    localparam int unsigned ZHW = (HW > ckre_pkg::SIZE_W) ? HW : ckre_pkg::SIZE_W;

    // Configuration registers.
    ckre_pkg::key_cfg_t              key_cfg_reg;
    logic [ckre_pkg::SIZE_W-1:0]     cfg_width_reg;
    logic [ckre_pkg::SIZE_W-1:0]     cfg_height_reg;

    // Input register.
    logic                            s1_valid_reg;
    ckre_pkg::pixel_t                s1_pix_reg;

    // Scan state.
    logic [CW-1:0]                   col_count_reg, col_count_next;
    logic [RW-1:0]                   row_count_reg, row_count_next;
    logic                            in_run_reg, in_run_next;
    logic [CW-1:0]                   run_start_reg, run_start_next;
    logic [SW-1:0]                   bound_left_reg, bound_left_next;
    logic [HW-1:0]                   bound_top_reg, bound_top_next;
    logic [SW-1:0]                   bound_right_reg, bound_right_next;
    logic [HW-1:0]                   bound_bottom_reg, bound_bottom_next;

    // Result register.
    logic                            out_valid_reg;

    logic                            out_free;
    logic                            fire;
    logic                            clear;
    logic [ZWW-1:0]                  width_ext;
    logic [ZHW-1:0]                  height_ext;
    logic [SW-1:0]                   width_eff;
    logic [HW-1:0]                   height_eff;
    logic                            row_last;
    logic                            frame_last;
    logic                            run_on;
    logic                            closed;
    logic                            emit;
    logic [CW-1:0]                   rb;
    logic [SW-1:0]                   re;
    logic [HW-1:0]                   rr_plus;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_cfg_reg.key_red   <= ckre_pkg::CHAN_MAX;
            key_cfg_reg.key_green <= ckre_pkg::CHAN_MAX;
            key_cfg_reg.key_blue  <= ckre_pkg::CHAN_MAX;
            key_cfg_reg.tol_red   <= '0;
            key_cfg_reg.tol_green <= '0;
            key_cfg_reg.tol_blue  <= '0;
            cfg_width_reg         <= 13'd4096;
            cfg_height_reg        <= 13'd4096;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ckre_pkg::REG_KEY_RED:      key_cfg_reg.key_red   <= cfg_data[7:0];
                ckre_pkg::REG_KEY_GREEN:    key_cfg_reg.key_green <= cfg_data[7:0];
                ckre_pkg::REG_KEY_BLUE:     key_cfg_reg.key_blue  <= cfg_data[7:0];
                ckre_pkg::REG_TOL_RED:      key_cfg_reg.tol_red   <= cfg_data[7:0];
                ckre_pkg::REG_TOL_GREEN:    key_cfg_reg.tol_green <= cfg_data[7:0];
                ckre_pkg::REG_TOL_BLUE:     key_cfg_reg.tol_blue  <= cfg_data[7:0];
                ckre_pkg::REG_IMAGE_WIDTH:  cfg_width_reg         <= cfg_data;
                ckre_pkg::REG_IMAGE_HEIGHT: cfg_height_reg        <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // The pipeline moves whenever the result register is empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_pix_reg.red   <= pix_red;
            s1_pix_reg.green <= pix_green;
            s1_pix_reg.blue  <= pix_blue;
        end
    end

    ckre_key_match u_key_match
    (
        .pixel   (s1_pix_reg),
        .key_cfg (key_cfg_reg),
        .clear   (clear)
    );

    // Effective frame size: zero acts as one, anything past the limit acts as the limit.
    always_comb
    begin
        width_ext  = ZWW'(cfg_width_reg);
        height_ext = ZHW'(cfg_height_reg);
        if (width_ext == '0)
            width_eff = SW'(1);
        else if (width_ext > ZWW'(MAX_WIDTH))
            width_eff = SW'(MAX_WIDTH);
        else
            width_eff = SW'(width_ext);
        if (height_ext == '0)
            height_eff = HW'(1);
        else if (height_ext > ZHW'(MAX_HEIGHT))
            height_eff = HW'(MAX_HEIGHT);
        else
            height_eff = HW'(height_ext);
    end

    // Run tracking and bounding box update for the pixel in the input register.
    always_comb
    begin
        row_last   = SW'(col_count_reg) >= (width_eff - SW'(1));
        frame_last = row_last && (HW'(row_count_reg) >= (height_eff - HW'(1)));

        // A run is in progress at this pixel if one was open or this pixel is opaque.
        run_on  = in_run_reg || !clear;
        rb      = in_run_reg ? run_start_reg : col_count_reg;
        closed  = run_on && (clear || row_last);
        re      = clear ? SW'(col_count_reg) : SW'(col_count_reg) + SW'(1);
        rr_plus = HW'(row_count_reg) + HW'(1);
        emit    = closed || frame_last;

        bound_left_next   = bound_left_reg;
        bound_top_next    = bound_top_reg;
        bound_right_next  = bound_right_reg;
        bound_bottom_next = bound_bottom_reg;
        if (closed)
        begin
            if (SW'(rb) < bound_left_reg)
                bound_left_next = SW'(rb);
            if (HW'(row_count_reg) < bound_top_reg)
                bound_top_next = HW'(row_count_reg);
            if (re > bound_right_reg)
                bound_right_next = re;
            if (rr_plus > bound_bottom_reg)
                bound_bottom_next = rr_plus;
        end

        in_run_next    = run_on && !closed;
        run_start_next = rb;
        col_count_next = col_count_reg + CW'(1);
        row_count_next = row_count_reg;
        if (frame_last)
        begin
            // The frame-end word has been built from the updated box; start over.
            in_run_next    = 1'b0;
            run_start_next = '0;
            col_count_next = '0;
            row_count_next = '0;
        end
        else if (row_last)
        begin
            col_count_next = '0;
            row_count_next = row_count_reg + RW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg    <= '0;
            row_count_reg    <= '0;
            in_run_reg       <= 1'b0;
            run_start_reg    <= '0;
            bound_left_reg   <= SW'(MAX_WIDTH);
            bound_top_reg    <= HW'(MAX_HEIGHT);
            bound_right_reg  <= '0;
            bound_bottom_reg <= '0;
        end
        else if (fire)
        begin
            col_count_reg  <= col_count_next;
            row_count_reg  <= row_count_next;
            in_run_reg     <= in_run_next;
            run_start_reg  <= run_start_next;
            if (frame_last)
            begin
                bound_left_reg   <= SW'(MAX_WIDTH);
                bound_top_reg    <= HW'(MAX_HEIGHT);
                bound_right_reg  <= '0;
                bound_bottom_reg <= '0;
            end
            else
            begin
                bound_left_reg   <= bound_left_next;
                bound_top_reg    <= bound_top_next;
                bound_right_reg  <= bound_right_next;
                bound_bottom_reg <= bound_bottom_next;
            end
        end
    end

    // Result register. A pixel that neither closes a run nor ends the frame
    // passes through without producing a word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= fire && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            run_valid  <= closed;
            run_begin  <= closed ? 12'(rb) : '0;
            run_end    <= closed ? 13'(re) : '0;
            run_row    <= closed ? 12'(row_count_reg) : '0;
            box_left   <= 13'(bound_left_next);
            box_top    <= 13'(bound_top_next);
            box_right  <= 13'(bound_right_next);
            box_bottom <= 13'(bound_bottom_next);
            frame_end  <= frame_last;
        end
    end

    assign out_valid = out_valid_reg;

    // A delivered run always lies inside the box that travels with it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_valid |->
            (box_left <= 13'(run_begin)) && (box_right >= run_end) &&
            (run_end > 13'(run_begin)))
        else $error("run outside its bounding box");

    // The frame-end pixel returns the scan to the top-left corner with no open run.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && frame_last |=>
            (col_count_reg == '0) && (row_count_reg == '0) && !in_run_reg)
        else $error("scan state not restarted after frame end");

    // The column counter always stays below the MAX_WIDTH parameter.
    assert property (@(posedge clk) disable iff (!rst_n)
        SW'(col_count_reg) < SW'(MAX_WIDTH))
        else $error("column counter out of range");

endmodule

@@ rtl/ckre_key_match.sv @@
// Color key window test: flags a pixel whose three channels all fall in the key window.
module ckre_key_match
(
    input  ckre_pkg::pixel_t   pixel,
    input  ckre_pkg::key_cfg_t key_cfg,
    output logic               clear
);

    // The upper bound is key plus tolerance, saturated at the channel maximum.
    function automatic logic chan_keyed(
        input logic [ckre_pkg::CHAN_W-1:0] v,
        input logic [ckre_pkg::CHAN_W-1:0] key,
        input logic [ckre_pkg::CHAN_W-1:0] tol
    );
        logic [ckre_pkg::CHAN_W:0]   sum;
        logic [ckre_pkg::CHAN_W-1:0] hi;
        sum = {1'b0, key} + {1'b0, tol};
        hi  = sum[ckre_pkg::CHAN_W] ? ckre_pkg::CHAN_MAX : sum[ckre_pkg::CHAN_W-1:0];
        return (v >= key) && (v <= hi);
    endfunction

    assign clear = chan_keyed(pixel.red,   key_cfg.key_red,   key_cfg.tol_red)   &&
                   chan_keyed(pixel.green, key_cfg.key_green, key_cfg.tol_green) &&
                   chan_keyed(pixel.blue,  key_cfg.key_blue,  key_cfg.tol_blue);

endmodule
